### rtl/scan_code_set1_to_ascii_assert.svh
// Assertion macros for the top RTL file of the scan code decoder.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef SCAN_CODE_SET1_TO_ASCII_ASSERT_SVH
`define SCAN_CODE_SET1_TO_ASCII_ASSERT_SVH

// Check a condition on the same clock edge as its trigger.
`define SC1A_ASSERT_NOW(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// Check a condition on the next clock edge after its trigger.
`define SC1A_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

### rtl/sc1a_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sc1a_pkg;

    localparam logic [7:0] PREFIX_BYTE = 8'hE0;
    localparam logic [6:0] LAST_KEY    = 7'h5D;
    localparam logic [6:0] KEY_DIVIDE  = 7'h35;
    localparam logic [6:0] KEY_CAPS    = 7'h3A;
    localparam logic [6:0] KEY_NUM     = 7'h45;
    localparam logic [6:0] KEY_SCROLL  = 7'h46;
    localparam logic [6:0] KEY_CTRL    = 7'h1D;
    localparam logic [6:0] KEY_ALT     = 7'h38;
    localparam logic [6:0] KEY_LSHIFT  = 7'h2A;
    localparam logic [6:0] KEY_RSHIFT  = 7'h36;
    localparam logic [6:0] CHAR_LOW_A  = 7'h61;
    localparam logic [6:0] CHAR_LOW_Z  = 7'h7A;

    // One decoded result beat
    typedef struct packed {
        logic       shift_held;
        logic       alt_held;
        logic       ctrl_held;
        logic       scroll_lock_on;
        logic       num_lock_on;
        logic       caps_lock_on;
        logic       led_update;
        logic [6:0] ascii_char;
        logic       char_valid;
    } result_t;

    // Key code to {shifted, plain} character; zero where the key prints nothing
    function automatic logic [13:0] glyph_pair(input logic [6:0] code);
        logic [13:0] g;
        begin
            case (code)
                7'h01: g = {7'h1B, 7'h1B};
                7'h02: g = {7'h21, 7'h31};
                7'h03: g = {7'h40, 7'h32};
                7'h04: g = {7'h23, 7'h33};
                7'h05: g = {7'h24, 7'h34};
                7'h06: g = {7'h25, 7'h35};
                7'h07: g = {7'h5E, 7'h36};
                7'h08: g = {7'h26, 7'h37};
                7'h09: g = {7'h2A, 7'h38};
                7'h0A: g = {7'h28, 7'h39};
                7'h0B: g = {7'h29, 7'h30};
                7'h0C: g = {7'h5F, 7'h2D};
                7'h0D: g = {7'h2B, 7'h3D};
                7'h0E: g = {7'h08, 7'h08};
                7'h0F: g = {7'h09, 7'h09};
                7'h10: g = {7'h51, 7'h71};
                7'h11: g = {7'h57, 7'h77};
                7'h12: g = {7'h45, 7'h65};
                7'h13: g = {7'h52, 7'h72};
                7'h14: g = {7'h54, 7'h74};
                7'h15: g = {7'h59, 7'h79};
                7'h16: g = {7'h55, 7'h75};
                7'h17: g = {7'h49, 7'h69};
                7'h18: g = {7'h4F, 7'h6F};
                7'h19: g = {7'h50, 7'h70};
                7'h1A: g = {7'h7B, 7'h5B};
                7'h1B: g = {7'h7D, 7'h5D};
                7'h1C: g = {7'h0A, 7'h0A};
                7'h1E: g = {7'h41, 7'h61};
                7'h1F: g = {7'h53, 7'h73};
                7'h20: g = {7'h44, 7'h64};
                7'h21: g = {7'h46, 7'h66};
                7'h22: g = {7'h47, 7'h67};
                7'h23: g = {7'h48, 7'h68};
                7'h24: g = {7'h4A, 7'h6A};
                7'h25: g = {7'h4B, 7'h6B};
                7'h26: g = {7'h4C, 7'h6C};
                7'h27: g = {7'h3A, 7'h3B};
                7'h28: g = {7'h22, 7'h27};
                7'h29: g = {7'h7E, 7'h60};
                7'h2B: g = {7'h7C, 7'h5C};
                7'h2C: g = {7'h5A, 7'h7A};
                7'h2D: g = {7'h58, 7'h78};
                7'h2E: g = {7'h43, 7'h63};
                7'h2F: g = {7'h56, 7'h76};
                7'h30: g = {7'h42, 7'h62};
                7'h31: g = {7'h4E, 7'h6E};
                7'h32: g = {7'h4D, 7'h6D};
                7'h33: g = {7'h3C, 7'h2C};
                7'h34: g = {7'h3E, 7'h2E};
                7'h35: g = {7'h3F, 7'h2F};
                7'h37: g = {7'h2A, 7'h2A};
                7'h39: g = {7'h20, 7'h20};
                // Keypad: digits only in the plain column
                7'h47: g = {7'h00, 7'h37};
                7'h48: g = {7'h00, 7'h38};
                7'h49: g = {7'h00, 7'h39};
                7'h4A: g = {7'h2D, 7'h2D};
                7'h4B: g = {7'h00, 7'h34};
                7'h4C: g = {7'h00, 7'h35};
                7'h4D: g = {7'h00, 7'h36};
                7'h4E: g = {7'h2B, 7'h2B};
                7'h4F: g = {7'h00, 7'h31};
                7'h50: g = {7'h00, 7'h32};
                7'h51: g = {7'h00, 7'h33};
                7'h52: g = {7'h00, 7'h30};
                7'h53: g = {7'h7F, 7'h2E};
                default: g = 14'h0000;
            endcase
            return g;
        end
    endfunction

endpackage

`default_nettype wire

### rtl/sc1a_glyph.sv
`timescale 1ns / 1ps
`default_nettype none

module sc1a_glyph
    import sc1a_pkg::*;
(
    input  wire logic [6:0] code,
    input  wire logic       ext,
    input  wire logic       shift,
    input  wire logic       caps,
    output logic      [6:0] ch
);

    logic [13:0] pair;
    logic [6:0]  plain;
    logic [6:0]  shifted;
    logic        is_letter;
    logic        level;

    // Look up both columns of the key
    assign pair    = glyph_pair(code);
    assign plain   = pair[6:0];
    assign shifted = pair[13:7];

    // Caps lock flips the level for letters only
    assign is_letter = (plain >= CHAR_LOW_A) && (plain <= CHAR_LOW_Z);
    assign level     = shift ^ (caps & is_letter);

    // Extended keys other than slash always take the second column
    always_comb
    begin
        if (ext && (code != KEY_DIVIDE))
        begin
            ch = shifted;
        end
        else
        begin
            ch = level ? shifted : plain;
        end
    end

endmodule

`default_nettype wire

### rtl/sc1a_core.sv
`timescale 1ns / 1ps
`default_nettype none

module sc1a_core
    import sc1a_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       fire,
    input  wire logic [7:0] scan_byte,
    output result_t         res
);

    logic       ext_reg, ext_next;
    logic       caps_reg, caps_next;
    logic       num_reg, num_next;
    logic       scroll_reg, scroll_next;
    logic [1:0] ctrl_reg, ctrl_next;
    logic [1:0] alt_reg, alt_next;
    logic       lshift_reg, lshift_next;
    logic       rshift_reg, rshift_next;

    logic       is_prefix;
    logic [6:0] code;
    logic       in_range;
    logic       is_make;
    logic       is_break;
    logic       led;
    logic [6:0] ch;

    // Classify the byte
    assign is_prefix = (scan_byte == PREFIX_BYTE);
    assign code      = scan_byte[6:0];
    assign in_range  = !is_prefix && (code <= LAST_KEY);
    assign is_make   = in_range && !scan_byte[7];
    assign is_break  = in_range && scan_byte[7];

    // Track modifiers, prefix and lock toggles
    always_comb
    begin
        ext_next    = is_prefix;
        caps_next   = caps_reg;
        num_next    = num_reg;
        scroll_next = scroll_reg;
        ctrl_next   = ctrl_reg;
        alt_next    = alt_reg;
        lshift_next = lshift_reg;
        rshift_next = rshift_reg;
        led         = 1'b0;
        if (is_make || is_break)
        begin
            if (code == KEY_CTRL)
            begin
                ctrl_next[ext_reg] = is_make;
            end
            if (code == KEY_ALT)
            begin
                alt_next[ext_reg] = is_make;
            end
            // Shift counts only the plain codes
            if ((code == KEY_LSHIFT) && !ext_reg)
            begin
                lshift_next = is_make;
            end
            if ((code == KEY_RSHIFT) && !ext_reg)
            begin
                rshift_next = is_make;
            end
        end
        if (is_make)
        begin
            unique case (code)
                KEY_NUM:
                begin
                    num_next = !num_reg;
                    led      = 1'b1;
                end
                KEY_CAPS:
                begin
                    caps_next = !caps_reg;
                    led       = 1'b1;
                end
                KEY_SCROLL:
                begin
                    scroll_next = !scroll_reg;
                    led         = 1'b1;
                end
                default:
                begin
                    led = 1'b0;
                end
            endcase
        end
    end

    // Map the key with the updated shift and caps levels
    sc1a_glyph u_glyph (
        .code  (code),
        .ext   (ext_reg),
        .shift (lshift_next | rshift_next),
        .caps  (caps_next),
        .ch    (ch)
    );

    // Assemble the result from the state after this byte
    always_comb
    begin
        res.char_valid     = is_make && (ch != 7'd0);
        res.ascii_char     = is_make ? ch : 7'd0;
        res.led_update     = led;
        res.caps_lock_on   = caps_next;
        res.num_lock_on    = num_next;
        res.scroll_lock_on = scroll_next;
        res.ctrl_held      = |ctrl_next;
        res.alt_held       = |alt_next;
        res.shift_held     = lshift_next | rshift_next;
    end

    // Commit the state when the byte moves on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ext_reg    <= 1'b0;
            caps_reg   <= 1'b0;
            num_reg    <= 1'b0;
            scroll_reg <= 1'b0;
            ctrl_reg   <= 2'b00;
            alt_reg    <= 2'b00;
            lshift_reg <= 1'b0;
            rshift_reg <= 1'b0;
        end
        else if (fire)
        begin
            ext_reg    <= ext_next;
            caps_reg   <= caps_next;
            num_reg    <= num_next;
            scroll_reg <= scroll_next;
            ctrl_reg   <= ctrl_next;
            alt_reg    <= alt_next;
            lshift_reg <= lshift_next;
            rshift_reg <= rshift_next;
        end
    end

endmodule

`default_nettype wire

### rtl/scan_code_set1_to_ascii.sv
`timescale 1ns / 1ps
`default_nettype none

// Scan code set 1 to ASCII decoder. Accepts one keyboard byte per beat on
// the s_ side and returns exactly one result beat per byte on the m_ side,
// in order. Throughput is one byte per clock while m_tready is high; the
// result beat is registered, as the input register feeds a combinational
// table lookup into the result register. While a result beat waits for
// m_tready, one more byte is taken into the input register and then the
// input stalls. The block keeps the extended-prefix flag, the ctrl, alt and
// shift key levels and the caps, num and scroll lock toggles; lock and
// modifier fields in each result show the state after that byte. led_update
// marks a lock toggle so the keyboard LEDs can be refreshed. Reset releases
// all keys and clears all locks.
module scan_code_set1_to_ascii
    import sc1a_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] scan_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [15:0] m_tdata    // [0] char_valid, [7:1] ascii_char, [8] led_update,
                                        // [9] caps_lock_on, [10] num_lock_on,
                                        // [11] scroll_lock_on, [12] ctrl_held,
                                        // [13] alt_held, [14] shift_held, [15] zero
);

    `include "scan_code_set1_to_ascii_assert.svh"

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg, out_valid_next;
    result_t    out_reg;
    result_t    res;
    logic       advance;
    logic       fire;
    logic       s_accept;

    // Move the input stage whenever the result register is free or draining
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;
    assign fire     = in_valid_reg && advance;

    sc1a_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .scan_byte (in_byte_reg),
        .res       (res)
    );

    // Next valid flags of both stages
    always_comb
    begin
        if (s_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end

        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Load payload registers on their beats
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_byte_reg <= s_tdata;
        end
        if (fire)
        begin
            out_reg <= res;
        end
    end

    // Drive the result beat
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_reg.shift_held, out_reg.alt_held, out_reg.ctrl_held,
                       out_reg.scroll_lock_on, out_reg.num_lock_on, out_reg.caps_lock_on,
                       out_reg.led_update, out_reg.ascii_char, out_reg.char_valid};

    `SC1A_ASSERT_NOW(a_char_valid_match, m_tvalid,
        out_reg.char_valid == (out_reg.ascii_char != 7'd0),
        "char_valid disagrees with ascii_char")
    `SC1A_ASSERT_NEXT(a_prefix_silent, fire && (in_byte_reg == PREFIX_BYTE),
        !out_reg.char_valid && !out_reg.led_update,
        "prefix byte produced a character or LED update")
    `SC1A_ASSERT_NOW(a_ready_when_empty, !m_tvalid, s_tready,
        "input stalled while result register is empty")

endmodule

`default_nettype wire

### dv/scan_code_set1_to_ascii_test.sv
`timescale 1ns / 1ps

module scan_code_set1_to_ascii_test;
    import sc1a_pkg::*;

    localparam int NUM_KEYS      = 94;
    localparam int RANDOM_BYTES  = 1500;
    localparam int LONG_HOLD     = 200;
    localparam int SETTLE_CYCLES = 10;
    localparam int CYCLE_LIMIT   = 500000;

    // Character per key code, unshifted and shifted columns
    localparam bit [6:0] UNSHIFTED_CHAR [NUM_KEYS] = '{
        7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
        7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
        7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
        7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
        7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
        7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
        7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
        7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
        7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h37,
        7'h38, 7'h39, 7'h2D, 7'h34, 7'h35, 7'h36, 7'h2B, 7'h31,
        7'h32, 7'h33, 7'h30, 7'h2E, 7'h00, 7'h00, 7'h00, 7'h00,
        7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
    };

    localparam bit [6:0] SHIFTED_CHAR [NUM_KEYS] = '{
        7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
        7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
        7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
        7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
        7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
        7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
        7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
        7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
        7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
        7'h00, 7'h00, 7'h2D, 7'h00, 7'h00, 7'h00, 7'h2B, 7'h00,
        7'h00, 7'h00, 7'h00, 7'h7F, 7'h00, 7'h00, 7'h00, 7'h00,
        7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
    };

    // Tracks keyboard state and holds the decoded results still owed by the block
    class key_decode_tracker;
        result_t    decoded_q[$];
        bit         prefix_seen;
        bit         caps_on;
        bit         num_on;
        bit         scroll_on;
        bit [1:0]   keys_down [NUM_KEYS];
        int         mismatches;

        function void take_byte(input logic [7:0] b);
            result_t    r;
            logic [6:0] code;
            logic [6:0] plain_ch;
            logic [6:0] ch;
            bit         ext;
            bit         lvl;
            bit         led;
            ch = '0;
            led = 1'b0;
            code = b[6:0];
            if (b == PREFIX_BYTE)
            begin
                prefix_seen = 1'b1;
            end
            else
            begin
                ext = prefix_seen;
                prefix_seen = 1'b0;
                if (code <= LAST_KEY)
                begin
                    if (b[7])
                    begin
                        keys_down[code][ext] = 1'b0;
                    end
                    else
                    begin
                        keys_down[code][ext] = 1'b1;
                        case (code)
                            KEY_NUM:
                            begin
                                num_on = !num_on;
                                led = 1'b1;
                            end
                            KEY_CAPS:
                            begin
                                caps_on = !caps_on;
                                led = 1'b1;
                            end
                            KEY_SCROLL:
                            begin
                                scroll_on = !scroll_on;
                                led = 1'b1;
                            end
                            default: ;
                        endcase
                        // Caps lock flips the shift level for letters only
                        plain_ch = UNSHIFTED_CHAR[code];
                        lvl = keys_down[KEY_LSHIFT][0] | keys_down[KEY_RSHIFT][0];
                        if (caps_on && plain_ch >= CHAR_LOW_A && plain_ch <= CHAR_LOW_Z)
                            lvl = !lvl;
                        if ((ext && code != KEY_DIVIDE) || lvl)
                            ch = SHIFTED_CHAR[code];
                        else
                            ch = plain_ch;
                    end
                end
            end
            r.char_valid     = (ch != 0);
            r.ascii_char     = ch;
            r.led_update     = led;
            r.caps_lock_on   = caps_on;
            r.num_lock_on    = num_on;
            r.scroll_lock_on = scroll_on;
            r.ctrl_held      = |keys_down[KEY_CTRL];
            r.alt_held       = |keys_down[KEY_ALT];
            r.shift_held     = keys_down[KEY_LSHIFT][0] | keys_down[KEY_RSHIFT][0];
            decoded_q.push_back(r);
        endfunction

        function void match_result(input logic [15:0] beat);
            result_t want;
            result_t got;
            bit      bad;
            got = beat[14:0];
            if (decoded_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: actual %h", beat);
                return;
            end
            want = decoded_q.pop_front();
            bad = (got.char_valid !== want.char_valid)
                || (got.ascii_char !== want.ascii_char)
                || (got.led_update !== want.led_update)
                || (got.caps_lock_on !== want.caps_lock_on)
                || (got.num_lock_on !== want.num_lock_on)
                || (got.scroll_lock_on !== want.scroll_lock_on)
                || (got.ctrl_held !== want.ctrl_held)
                || (got.alt_held !== want.alt_held)
                || (got.shift_held !== want.shift_held)
                || (beat[15] !== 1'b0);
            if (bad)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: expected %h actual %h", {1'b0, want}, beat);
            end
        endfunction

        function int outstanding();
            return decoded_q.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;

    key_decode_tracker tracker;
    int  sent_count;
    int  cycles;
    bit  no_gaps;
    bit  hold_output;

    scan_code_set1_to_ascii u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Idle cycles before the next beat on either side
    function automatic int draw_gap();
        if (no_gaps || $urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(0, 17);
    endfunction

    // Sample both handshakes at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                tracker.take_byte(s_tdata);
            if (m_tvalid && m_tready)
                tracker.match_result(m_tdata);
        end
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL scan_code_set1_to_ascii");
            $finish;
        end
    end

    // Result side: random stalls, plus one long hold-off on request
    initial
    begin : result_sink
        int wait_cycles;
        m_tready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_output)
            begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                hold_output = 1'b0;
            end
            wait_cycles = draw_gap();
            if (wait_cycles > 0)
            begin
                m_tready <= 1'b0;
                repeat (wait_cycles) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            @(negedge clk);
        end
    end

    // Offer one byte after a random gap; return at the falling edge after the beat
    task automatic send_byte(input logic [7:0] b);
        int wait_cycles;
        wait_cycles = draw_gap();
        if (wait_cycles > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (wait_cycles) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge clk); while (!s_tready);
        sent_count++;
        @(negedge clk);
    endtask

    task automatic key_event(input logic [6:0] code, input bit ext, input bit brk);
        if (ext)
            send_byte(PREFIX_BYTE);
        send_byte({brk, code});
    endtask

    // Drop valid and wait until every owed result has come back
    task automatic settle_block();
        s_tvalid <= 1'b0;
        while (tracker.outstanding() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // One random keyboard action, mostly well-formed make/break pairs
    task automatic random_action();
        logic [6:0] mod_keys [4];
        logic [6:0] lock_keys [3];
        logic [6:0] code;
        bit         ext;
        int         pick;
        mod_keys  = '{KEY_LSHIFT, KEY_RSHIFT, KEY_CTRL, KEY_ALT};
        lock_keys = '{KEY_CAPS, KEY_NUM, KEY_SCROLL};
        pick = $urandom_range(0, 99);
        ext  = ($urandom_range(0, 3) == 0);
        if (pick < 10)
        begin
            send_byte(8'($urandom_range(0, 255)));
        end
        else if (pick < 25)
        begin
            key_event(mod_keys[$urandom_range(0, 3)], ext, 1'($urandom_range(0, 1)));
        end
        else if (pick < 30)
        begin
            code = lock_keys[$urandom_range(0, 2)];
            key_event(code, ext, 1'b0);
            key_event(code, ext, 1'b1);
        end
        else if (pick < 35)
        begin
            // Stray prefix or break without a make
            if ($urandom_range(0, 1))
            begin
                send_byte(PREFIX_BYTE);
                send_byte(8'($urandom_range(0, 255)));
            end
            else
            begin
                key_event(7'($urandom_range(0, LAST_KEY)), ext, 1'b1);
            end
        end
        else
        begin
            code = 7'($urandom_range(0, LAST_KEY));
            key_event(code, ext, 1'b0);
            if ($urandom_range(0, 3) == 0)
                key_event(code, ext, 1'b0);
            key_event(code, ext, 1'b1);
        end
    endtask

    initial
    begin
        bit did_hold;
        bit did_pause;
        tracker     = new();
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        no_gaps     = 1'b0;
        hold_output = 1'b0;
        did_hold    = 1'b0;
        did_pause   = 1'b0;
        sent_count  = 0;
        cycles      = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: byte extremes, prefix handling, locks, modifiers, columns
        send_byte(8'h00);
        send_byte(8'hFF);
        key_event(KEY_DIVIDE, 1'b1, 1'b0);
        send_byte(PREFIX_BYTE);
        send_byte(PREFIX_BYTE);
        send_byte({1'b0, LAST_KEY + 7'd1});
        key_event(KEY_CAPS, 1'b0, 1'b0);
        key_event(7'h1E, 1'b0, 1'b0);
        key_event(KEY_LSHIFT, 1'b0, 1'b0);
        key_event(7'h1E, 1'b0, 1'b0);
        key_event(7'h02, 1'b0, 1'b0);
        key_event(KEY_DIVIDE, 1'b1, 1'b0);
        key_event(KEY_LSHIFT, 1'b0, 1'b1);
        key_event(KEY_RSHIFT, 1'b1, 1'b0);
        key_event(KEY_CTRL, 1'b1, 1'b0);
        key_event(KEY_CTRL, 1'b0, 1'b1);
        key_event(KEY_ALT, 1'b0, 1'b0);
        key_event(KEY_SCROLL, 1'b1, 1'b0);
        key_event(KEY_NUM, 1'b0, 1'b0);
        key_event(7'h53, 1'b1, 1'b0);
        key_event(LAST_KEY, 1'b0, 1'b0);
        key_event(7'h18, 1'b0, 1'b0);
        settle_block();

        // Random traffic with a long output hold, a full pause and gapless stretches
        sent_count = 0;
        while (sent_count < RANDOM_BYTES)
        begin
            no_gaps = (sent_count >= 150 && sent_count < 300)
                || (sent_count >= 1200 && sent_count < 1320);
            if (!did_hold && sent_count >= 400)
            begin
                did_hold = 1'b1;
                hold_output = 1'b1;
            end
            if (!did_pause && sent_count >= 900)
            begin
                did_pause = 1'b1;
                settle_block();
            end
            random_action();
        end

        settle_block();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.outstanding() == 0)
            $display("PASS scan_code_set1_to_ascii");
        else
            $display("FAIL scan_code_set1_to_ascii");
        $finish;
    end

endmodule
